FILE: design/prate_pkg.sv
package prate_pkg;

   // Field widths
   localparam int SAMPLE_W   = 18;
   localparam int TIME_W     = 32;
   localparam int INTV_W     = 16;
   localparam int RATE_W     = 8;
   localparam int RATE_MAX   = (1 << RATE_W) - 1;

   // Stream and register port widths
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 18;

   // Serial divider
   localparam int DIV_W   = 16;
   localparam int DIV_CNT_W = 4;
   localparam logic [DIV_W-1:0] RATE_NUM = 16'd60000;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_INTV  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_INTV  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_RATE  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_RATE  = 3'd5;

   // Register reset values
   localparam logic [SAMPLE_W-1:0] LEVEL_RST    = 18'd40000;
   localparam logic [SAMPLE_W-1:0] STEP_RST     = 18'd3000;
   localparam logic [INTV_W-1:0]   MIN_INTV_RST = 16'd400;
   localparam logic [INTV_W-1:0]   MAX_INTV_RST = 16'd1500;
   localparam logic [RATE_W-1:0]   MIN_RATE_RST = 8'd50;
   localparam logic [RATE_W-1:0]   MAX_RATE_RST = 8'd150;

   // Divider request and result
   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   // Ring control and status
   typedef struct packed {
      logic push;
      logic sum_start;
   } ring_ctl_type;

   typedef struct packed {
      logic full;
      logic sum_done;
   } ring_sts_type;

endpackage

FILE: design/prate_div.sv
module prate_div (
   input  logic                   clock,
   input  logic                   reset,
   input  prate_pkg::div_req_type div_req,
   output prate_pkg::div_rsp_type div_rsp
);
   import prate_pkg::*;

   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_W:0]       shifted;

   // One quotient bit per cycle, restoring
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = DIV_CNT_W'(DIV_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = DIV_W'(shifted - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: design/prate_ring.sv
module prate_ring #(
   parameter int RING_DEPTH = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  prate_pkg::ring_ctl_type            ring_ctl,
   input  logic [prate_pkg::RATE_W-1:0]       push_rate,
   output prate_pkg::ring_sts_type            ring_sts,
   output logic [$clog2(prate_pkg::RATE_MAX*RING_DEPTH+1)-1:0] ring_sum
);
   import prate_pkg::*;

   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int SUM_W = $clog2(RATE_MAX * RING_DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

   logic [RATE_W-1:0] mem [0:RING_DEPTH-1];
   logic [RATE_W-1:0] rd_data_ff;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             full_ff, full_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             rd_active_ff, rd_active_in;
   logic             acc_valid_ff, acc_valid_in;
   logic             done_ff, done_in;
   logic [SUM_W-1:0] sum_ff, sum_in;

   // Ring storage, registered read
   always_ff @(posedge clock) begin
      if (ring_ctl.push) begin
         mem[idx_ff] <= push_rate;
      end
      if (rd_active_ff) begin
         rd_data_ff <= mem[ptr_ff];
      end
   end

   // Write pointer, fill flag and one-entry-per-cycle sum sweep
   always_comb begin
      idx_in       = idx_ff;
      full_in      = full_ff;
      ptr_in       = ptr_ff;
      rd_active_in = rd_active_ff;
      acc_valid_in = rd_active_ff;
      done_in      = acc_valid_ff && !rd_active_ff;
      sum_in       = sum_ff;
      if (ring_ctl.push) begin
         if (idx_ff == IDX_LAST) begin
            idx_in  = '0;
            full_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (acc_valid_ff) begin
         sum_in = sum_ff + SUM_W'(rd_data_ff);
      end
      if (rd_active_ff) begin
         if (ptr_ff == IDX_LAST) begin
            rd_active_in = 1'b0;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
      if (ring_ctl.sum_start) begin
         ptr_in       = '0;
         rd_active_in = 1'b1;
         sum_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      ptr_ff <= ptr_in;
      if (reset) begin
         idx_ff       <= '0;
         full_ff      <= 1'b0;
         rd_active_ff <= 1'b0;
         acc_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         full_ff      <= full_in;
         rd_active_ff <= rd_active_in;
         acc_valid_ff <= acc_valid_in;
         done_ff      <= done_in;
      end
   end

   assign ring_sts.full     = full_ff;
   assign ring_sts.sum_done = done_ff;
   assign ring_sum          = sum_ff;

endmodule

FILE: design/pulse_rate_estimator.sv
// Pulse rate estimator: one result transaction per sample transaction. A sample with no
// rise, or a rise outside the interval window, is answered straight after evaluation; a
// rise that reaches the rate test waits for the 16-step serial divider forming 60000 /
// interval, and is answered when the rate is rejected or is accepted before the ring
// has filled; once the rate ring has filled, an accepted beat also waits while the
// ring is swept one entry per cycle and the same divider then forms the average. One
// sample is in work at a time; the next sample is taken as soon as the previous result
// sits in the output register.
module pulse_rate_estimator #(
   parameter int RING_DEPTH = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: ir_sample[17:0], time_ms[49:18], zero fill [55:50]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [prate_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // rsp_tdata: rate_bpm[7:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [prate_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // rsp_tuser: beat_accepted[0]
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [prate_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [prate_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import prate_pkg::*;

   localparam int SUM_W = $clog2(RATE_MAX * RING_DEPTH + 1);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_EVAL = 7'b0000010,
      ST_RATE = 7'b0000100,
      ST_RING = 7'b0001000,
      ST_SUM  = 7'b0010000,
      ST_AVG  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] level_ff, level_in;
   logic [SAMPLE_W-1:0] step_ff, step_in;
   logic [INTV_W-1:0]   min_intv_ff, min_intv_in;
   logic [INTV_W-1:0]   max_intv_ff, max_intv_in;
   logic [RATE_W-1:0]   min_rate_ff, min_rate_in;
   logic [RATE_W-1:0]   max_rate_ff, max_rate_in;

   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [TIME_W-1:0]   last_ff, last_in;
   logic [RATE_W-1:0]   held_ff, held_in;
   logic                beat_ff, beat_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [TIME_W-1:0]   time_ff, time_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]   rsp_rate_ff, rsp_rate_in;
   logic                rsp_beat_ff, rsp_beat_in;

   div_req_type       div_req;
   div_rsp_type       div_rsp;
   ring_ctl_type      ring_ctl;
   ring_sts_type      ring_sts;
   logic [SUM_W-1:0]  ring_sum;

   logic                rise;
   logic [TIME_W-1:0]   interval;
   logic                intv_ok;
   logic                rate_ok;

   prate_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   prate_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .ring_ctl  (ring_ctl),
      .push_rate (div_rsp.quotient[RATE_W-1:0]),
      .ring_sts  (ring_sts),
      .ring_sum  (ring_sum)
   );

   // Register writes
   always_comb begin
      level_in    = level_ff;
      step_in     = step_ff;
      min_intv_in = min_intv_ff;
      max_intv_in = max_intv_ff;
      min_rate_in = min_rate_ff;
      max_rate_in = max_rate_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_LEVEL:    level_in    = csr_wdata;
            CSR_STEP:     step_in     = csr_wdata;
            CSR_MIN_INTV: min_intv_in = csr_wdata[INTV_W-1:0];
            CSR_MAX_INTV: max_intv_in = csr_wdata[INTV_W-1:0];
            CSR_MIN_RATE: min_rate_in = csr_wdata[RATE_W-1:0];
            CSR_MAX_RATE: max_rate_in = csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // Rise, interval and rate tests
   assign rise     = (sample_ff > level_ff)
                     && ({1'b0, sample_ff} > ({1'b0, prev_ff} + {1'b0, step_ff}));
   assign interval = time_ff - last_ff;
   assign intv_ok  = (interval > TIME_W'(min_intv_ff)) && (interval < TIME_W'(max_intv_ff));
   assign rate_ok  = (div_rsp.quotient > DIV_W'(min_rate_ff))
                     && (div_rsp.quotient < DIV_W'(max_rate_ff));

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      last_in      = last_ff;
      held_in      = held_ff;
      beat_in      = beat_ff;
      sample_in    = sample_ff;
      time_in      = time_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_beat_in  = rsp_beat_ff;
      div_req      = '0;
      ring_ctl     = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sample_in = req_tdata[SAMPLE_W-1:0];
               time_in   = req_tdata[SAMPLE_W +: TIME_W];
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (rise) begin
               last_in = time_ff;
            end
            if (rise && intv_ok) begin
               div_req.start    = 1'b1;
               div_req.dividend = RATE_NUM;
               div_req.divisor  = interval[DIV_W-1:0];
               state_in         = ST_RATE;
            end else begin
               prev_in  = sample_ff;
               beat_in  = 1'b0;
               state_in = ST_DONE;
            end
         end
         ST_RATE: begin
            if (div_rsp.done) begin
               if (rate_ok) begin
                  ring_ctl.push = 1'b1;
                  beat_in       = 1'b1;
                  state_in      = ST_RING;
               end else begin
                  prev_in  = sample_ff;
                  beat_in  = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_RING: begin
            if (ring_sts.full) begin
               ring_ctl.sum_start = 1'b1;
               state_in           = ST_SUM;
            end else begin
               held_in  = div_rsp.quotient[RATE_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_SUM: begin
            if (ring_sts.sum_done) begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(ring_sum);
               div_req.divisor  = DIV_W'(RING_DEPTH);
               state_in         = ST_AVG;
            end
         end
         ST_AVG: begin
            if (div_rsp.done) begin
               held_in  = div_rsp.quotient[RATE_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_rate_in  = held_ff;
               rsp_beat_in  = beat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      time_ff     <= time_in;
      beat_ff     <= beat_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_beat_ff <= rsp_beat_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= LEVEL_RST;
         step_ff      <= STEP_RST;
         min_intv_ff  <= MIN_INTV_RST;
         max_intv_ff  <= MAX_INTV_RST;
         min_rate_ff  <= MIN_RATE_RST;
         max_rate_ff  <= MAX_RATE_RST;
         prev_ff      <= '0;
         last_ff      <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         step_ff      <= step_in;
         min_intv_ff  <= min_intv_in;
         max_intv_ff  <= max_intv_in;
         min_rate_ff  <= min_rate_in;
         max_rate_ff  <= max_rate_in;
         prev_ff      <= prev_in;
         last_ff      <= last_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_rate_ff;
   assign rsp_tuser  = rsp_beat_ff;

endmodule

FILE: design/prate_checker.sv
module prate_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [prate_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [prate_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                               rsp_tuser
);
   import prate_pkg::*;

   logic req_acc;

   assign req_acc = req_tvalid && req_tready && (req_tdata == req_tdata);

   // After reset the block is ready and holds no result
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

   // One sample in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("sample taken while another is in work");

   // A result never appears in the cycle right after a sample is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !$rose(rsp_tvalid))
      else $error("result appeared without processing");

   // An accepted beat always carries a nonzero rate
   a_beat_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata != '0)
      else $error("beat flagged with zero rate");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind pulse_rate_estimator prate_checker u_prate_checker (.*);
